// ----- rtl/color_key_sprite_blit_assert.svh -----
// Assertion helpers for the color-key sprite blitter.
// Both expect clk_i and rst_ni in scope.
`ifndef COLOR_KEY_SPRITE_BLIT_ASSERT_SVH
`define COLOR_KEY_SPRITE_BLIT_ASSERT_SVH

// Same-cycle implication.
`define CKB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ckb assertion failed (same cycle)");

// Next-cycle implication.
`define CKB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ckb assertion failed (next cycle)");

`endif

// ----- rtl/ckb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ckb_pkg;

  localparam int unsigned MAX_BAND_DIM   = 512;
  localparam int unsigned MAX_SPRITE_DIM = 128;

  // Register widths as written on the config port
  localparam int unsigned BW_CFG_W = 10;
  localparam int unsigned SW_CFG_W = 8;
  localparam int unsigned CTR_W    = 11;

  // Widths of clamped values and positions
  localparam int unsigned BAND_W = $clog2(MAX_BAND_DIM + 1);
  localparam int unsigned SPR_W  = $clog2(MAX_SPRITE_DIM + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_SPRITE_DIM);
  localparam int unsigned POS_W  = $clog2(MAX_BAND_DIM);
  localparam int unsigned CALC_W = ((CTR_W > SPR_W) ? CTR_W : SPR_W) + 2;
  localparam int unsigned MUL_W  = POS_W + BAND_W;

  localparam int unsigned PIX_W      = 16;
  localparam int unsigned ADDR_W     = 18;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [BW_CFG_W-1:0] RST_BAND_WIDTH    = BW_CFG_W'(320);
  localparam logic [BW_CFG_W-1:0] RST_BAND_HEIGHT   = BW_CFG_W'(240);
  localparam logic [SW_CFG_W-1:0] RST_SPRITE_WIDTH  = SW_CFG_W'(64);
  localparam logic [SW_CFG_W-1:0] RST_SPRITE_HEIGHT = SW_CFG_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND_WIDTH    = 3'd0,
    REG_BAND_HEIGHT   = 3'd1,
    REG_SPRITE_WIDTH  = 3'd2,
    REG_SPRITE_HEIGHT = 3'd3,
    REG_CENTER_X      = 3'd4,
    REG_CENTER_Y      = 3'd5
  } cfg_reg_e;

  // Clamped configuration seen by the datapath
  typedef struct packed {
    logic [BAND_W-1:0]       bw;
    logic [BAND_W-1:0]       bh;
    logic [SPR_W-1:0]        sw;
    logic [SPR_W-1:0]        sh;
    logic signed [CTR_W-1:0] cx;
    logic signed [CTR_W-1:0] cy;
  } cfg_t;

  // Placement result for one pixel
  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] bx;
    logic [POS_W-1:0] by;
  } pos_t;

  function automatic logic [PIX_W-1:0] swap_bytes(input logic [PIX_W-1:0] v);
    swap_bytes = {v[7:0], v[15:8]};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ckb_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ckb_pix_if import ckb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             first_pixel;

  modport source (output valid, output pixel, output first_pixel, input ready);
  modport sink   (input valid, input pixel, input first_pixel, output ready);
endinterface

interface ckb_wr_if import ckb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] dest_address;
  logic [PIX_W-1:0]  write_data;

  modport source (output valid, output dest_address, output write_data, input ready);
  modport sink   (input valid, input dest_address, input write_data, output ready);
endinterface

interface ckb_cfg_if import ckb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/ckb_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ckb_cfg_regs import ckb_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ckb_cfg_if.sink    cfg_i,
  output cfg_t       cfg_o
);

  logic [BW_CFG_W-1:0]     band_w_q, band_h_q;
  logic [SW_CFG_W-1:0]     spr_w_q, spr_h_q;
  logic signed [CTR_W-1:0] ctr_x_q, ctr_y_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_w_q <= RST_BAND_WIDTH;
      band_h_q <= RST_BAND_HEIGHT;
      spr_w_q  <= RST_SPRITE_WIDTH;
      spr_h_q  <= RST_SPRITE_HEIGHT;
      ctr_x_q  <= '0;
      ctr_y_q  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_BAND_WIDTH:    band_w_q <= BW_CFG_W'(cfg_i.data);
        REG_BAND_HEIGHT:   band_h_q <= BW_CFG_W'(cfg_i.data);
        REG_SPRITE_WIDTH:  spr_w_q  <= SW_CFG_W'(cfg_i.data);
        REG_SPRITE_HEIGHT: spr_h_q  <= SW_CFG_W'(cfg_i.data);
        REG_CENTER_X:      ctr_x_q  <= CTR_W'(cfg_i.data);
        REG_CENTER_Y:      ctr_y_q  <= CTR_W'(cfg_i.data);
        default: ;
      endcase
    end
  end

  function automatic logic [BAND_W-1:0] clamp_band(input logic [BW_CFG_W-1:0] v);
    if (int'(v) > int'(MAX_BAND_DIM)) clamp_band = BAND_W'(MAX_BAND_DIM);
    else                              clamp_band = BAND_W'(v);
  endfunction

  // zero counts as one, oversize saturates
  function automatic logic [SPR_W-1:0] clamp_sprite(input logic [SW_CFG_W-1:0] v);
    if (v == '0)                                  clamp_sprite = SPR_W'(1);
    else if (int'(v) > int'(MAX_SPRITE_DIM))      clamp_sprite = SPR_W'(MAX_SPRITE_DIM);
    else                                          clamp_sprite = SPR_W'(v);
  endfunction

  always_comb begin
    cfg_o.bw = clamp_band(band_w_q);
    cfg_o.bh = clamp_band(band_h_q);
    cfg_o.sw = clamp_sprite(spr_w_q);
    cfg_o.sh = clamp_sprite(spr_h_q);
    cfg_o.cx = ctr_x_q;
    cfg_o.cy = ctr_y_q;
  end

endmodule

`default_nettype wire

// ----- rtl/ckb_tracker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "color_key_sprite_blit_assert.svh"

module ckb_tracker import ckb_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             adv_i,
  input  wire logic [PIX_W-1:0] pixel_i,
  input  wire logic             first_i,
  output pos_t                  pos_o
);

  logic [PIX_W-1:0] key_q, key_d;
  logic [CNT_W-1:0] col_q, col_d, row_q, row_d;
  logic [CNT_W-1:0] col_s, row_s, col_c, row_c;
  logic [SPR_W-1:0] col_p, row_p;
  logic signed [CALC_W-1:0] bx, by;
  logic in_band;

  always_comb begin
    // a marked pixel restarts the sprite and sets the key
    key_d = first_i ? pixel_i : key_q;
    col_s = first_i ? '0 : col_q;
    row_s = first_i ? '0 : row_q;

    // drop counts left stale by a smaller sprite size
    col_c = (SPR_W'(col_s) >= cfg_i.sw) ? '0 : col_s;
    row_c = (SPR_W'(row_s) >= cfg_i.sh) ? '0 : row_s;

    bx = CALC_W'(cfg_i.cx) - $signed(CALC_W'(cfg_i.sw >> 1)) + $signed(CALC_W'(col_c));
    by = CALC_W'(cfg_i.cy) - $signed(CALC_W'(cfg_i.sh >> 1)) + $signed(CALC_W'(row_c));

    in_band = (bx >= 0) && (bx < $signed(CALC_W'(cfg_i.bw)))
           && (by >= 0) && (by < $signed(CALC_W'(cfg_i.bh)));

    pos_o.hit = in_band && (pixel_i != key_d);
    pos_o.bx  = bx[POS_W-1:0];
    pos_o.by  = by[POS_W-1:0];

    // advance raster position
    col_p = SPR_W'(col_c) + SPR_W'(1);
    row_p = SPR_W'(row_c) + SPR_W'(1);
    if (col_p >= cfg_i.sw) begin
      col_d = '0;
      row_d = (row_p >= cfg_i.sh) ? '0 : row_p[CNT_W-1:0];
    end else begin
      col_d = col_p[CNT_W-1:0];
      row_d = row_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      col_q <= '0;
      row_q <= '0;
    end else if (adv_i) begin
      key_q <= key_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  `CKB_ASSERT_NEXT(a_key_latch, adv_i && first_i, key_q == $past(pixel_i))
  `CKB_ASSERT_NEXT(a_first_restart, adv_i && first_i && (cfg_i.sw > SPR_W'(1)),
                   (col_q == CNT_W'(1)) && (row_q == '0))

endmodule

`default_nettype wire

// ----- rtl/color_key_sprite_blit.sv -----
// A pixel word accepted into the input register moves on into the result register
//   once that is free, and its write word is offered from the result register.
// Throughput: one pixel word per cycle while no write word waits; the counters step
//   once per word; the band address is one 9x10 multiply plus add in the same stage.
// Reset (rst_ni low, asynchronous): config registers return to 320/240/64/64/0/0,
//   key and counters clear, both pipeline registers empty.
`timescale 1ns / 1ps
`default_nettype none
`include "color_key_sprite_blit_assert.svh"

module color_key_sprite_blit import ckb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ckb_cfg_if.sink   cfg_i,
  ckb_pix_if.sink   pixel_i,
  ckb_wr_if.source  wr_o
);

  cfg_t cfg;
  pos_t pos;

  // Input register
  logic             in_vld_q;
  logic [PIX_W-1:0] in_pix_q;
  logic             in_first_q;

  // Result register
  logic              out_vld_q, out_vld_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [PIX_W-1:0]  data_q, data_d;

  logic             adv;
  logic [MUL_W-1:0] prod;

  ckb_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Key and raster counters move only when the held word moves on
  ckb_tracker u_trk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .adv_i   (adv && in_vld_q),
    .pixel_i (in_pix_q),
    .first_i (in_first_q),
    .pos_o   (pos)
  );

  // Result register is free when empty or being drained this cycle
  assign adv           = !out_vld_q || wr_o.ready;
  assign pixel_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (pixel_i.ready) begin
      in_vld_q <= pixel_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pixel_i.ready && pixel_i.valid) begin
      in_pix_q   <= pixel_i.pixel;
      in_first_q <= pixel_i.first_pixel;
    end
  end

  // Band address: row * band width + column, always below 2^18 once in band
  always_comb begin
    prod      = pos.by * cfg.bw;
    addr_d    = ADDR_W'(prod + MUL_W'(pos.bx));
    data_d    = swap_bytes(in_pix_q);
    out_vld_d = in_vld_q && pos.hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= out_vld_d;
    end
  end

  // Hold the payload while a write word waits
  always_ff @(posedge clk_i) begin
    if (adv && out_vld_d) begin
      addr_q <= addr_d;
      data_q <= data_d;
    end
  end

  assign wr_o.valid        = out_vld_q;
  assign wr_o.dest_address = addr_q;
  assign wr_o.write_data   = data_q;

  `CKB_ASSERT_NOW(a_stall_cause, !pixel_i.ready, in_vld_q && out_vld_q && !wr_o.ready)
  `CKB_ASSERT_NEXT(a_no_phantom, adv && !in_vld_q, !out_vld_q)
  `CKB_ASSERT_NEXT(a_drop_first, adv && in_vld_q && in_first_q, !out_vld_q)

endmodule

`default_nettype wire

// ----- tb/tb_color_key_sprite_blit.sv -----
`timescale 1ns / 1ps

typedef struct {
  logic [ckb_pkg::ADDR_W-1:0] addr;
  logic [ckb_pkg::PIX_W-1:0]  data;
} band_write_t;

// Tracks the blitter's registers, key and sprite position, and holds the band
// writes still owed by the block.
class blit_tracker;
  logic [ckb_pkg::BW_CFG_W-1:0]     band_w, band_h;
  logic [ckb_pkg::SW_CFG_W-1:0]     spr_w, spr_h;
  logic signed [ckb_pkg::CTR_W-1:0] ctr_x, ctr_y;
  logic [ckb_pkg::PIX_W-1:0]        key;
  int                               col, row;
  band_write_t                      due[$];
  int                               errors, matched;

  function new();
    band_w  = ckb_pkg::RST_BAND_WIDTH;
    band_h  = ckb_pkg::RST_BAND_HEIGHT;
    spr_w   = ckb_pkg::RST_SPRITE_WIDTH;
    spr_h   = ckb_pkg::RST_SPRITE_HEIGHT;
    ctr_x   = '0;
    ctr_y   = '0;
    key     = '0;
    col     = 0;
    row     = 0;
    errors  = 0;
    matched = 0;
  endfunction

  static function int sprite_dim(int v);
    if (v < 1) return 1;
    if (v > int'(ckb_pkg::MAX_SPRITE_DIM)) return int'(ckb_pkg::MAX_SPRITE_DIM);
    return v;
  endfunction

  static function int band_dim(int v);
    if (v > int'(ckb_pkg::MAX_BAND_DIM)) return int'(ckb_pkg::MAX_BAND_DIM);
    return v;
  endfunction

  function void set_reg(ckb_pkg::cfg_reg_e idx, logic [ckb_pkg::CFG_DATA_W-1:0] v);
    case (idx)
      ckb_pkg::REG_BAND_WIDTH:    band_w = v[ckb_pkg::BW_CFG_W-1:0];
      ckb_pkg::REG_BAND_HEIGHT:   band_h = v[ckb_pkg::BW_CFG_W-1:0];
      ckb_pkg::REG_SPRITE_WIDTH:  spr_w  = v[ckb_pkg::SW_CFG_W-1:0];
      ckb_pkg::REG_SPRITE_HEIGHT: spr_h  = v[ckb_pkg::SW_CFG_W-1:0];
      ckb_pkg::REG_CENTER_X:      ctr_x  = v[ckb_pkg::CTR_W-1:0];
      ckb_pkg::REG_CENTER_Y:      ctr_y  = v[ckb_pkg::CTR_W-1:0];
      default: ;
    endcase
  endfunction

  function void take_pixel(logic [ckb_pkg::PIX_W-1:0] pix, logic first);
    int          sw, sh, bw, bh, bx, by, addr_full;
    band_write_t w;
    sw = sprite_dim(int'(spr_w));
    sh = sprite_dim(int'(spr_h));
    bw = band_dim(int'(band_w));
    bh = band_dim(int'(band_h));
    if (first) begin
      key = pix;
      col = 0;
      row = 0;
    end
    if (col >= sw) col = 0;
    if (row >= sh) row = 0;
    bx = int'(ctr_x) - sw / 2 + col;
    by = int'(ctr_y) - sh / 2 + row;
    if (bx >= 0 && bx < bw && by >= 0 && by < bh && pix != key) begin
      addr_full = by * bw + bx;
      w.addr = addr_full[ckb_pkg::ADDR_W-1:0];
      w.data = {pix[7:0], pix[15:8]};
      due.push_back(w);
    end
    col++;
    if (col >= sw) begin
      col = 0;
      row++;
      if (row >= sh) row = 0;
    end
  endfunction

  function void match_write(logic [ckb_pkg::ADDR_W-1:0] addr, logic [ckb_pkg::PIX_W-1:0] data);
    band_write_t w;
    if (due.size() == 0) begin
      $error("write word with nothing pending: dest_address %0d write_data %h", addr, data);
      errors++;
      return;
    end
    w = due.pop_front();
    if (w.addr !== addr) begin
      $error("dest_address: expected %0d, got %0d", w.addr, addr);
      errors++;
    end
    if (w.data !== data) begin
      $error("write_data: expected %h, got %h", w.data, data);
      errors++;
    end
    matched++;
  endfunction
endclass

module tb_color_key_sprite_blit;
  import ckb_pkg::*;

  localparam int RANDOM_ITEMS  = 850;
  localparam int CYCLE_LIMIT   = 400000;
  // Two pipeline stages; the extra wait also covers words that write nothing.
  localparam int SETTLE_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  bit          src_burst, snk_burst;
  int          cycles, settings, pixels_sent;
  blit_tracker tracker = new();

  ckb_cfg_if cfg_if ();
  ckb_pix_if pix_if ();
  ckb_wr_if  wr_if ();

  color_key_sprite_blit dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cfg_i   (cfg_if.sink),
    .pixel_i (pix_if.sink),
    .wr_o    (wr_if.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a correct run ends far below this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Check every write word the band side takes.
  always @(posedge clk) begin
    if (rst_n && wr_if.valid && wr_if.ready) begin
      tracker.match_write(wr_if.dest_address, wr_if.write_data);
    end
  end

  // Band side: draw a stall per word, or none at all in burst phases.
  initial begin
    int stall;
    wr_if.ready <= 1'b0;
    wait (rst_n);
    forever begin
      stall = snk_burst ? 0 : $urandom_range(7);
      if (stall > 0) begin
        wr_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      wr_if.ready <= 1'b1;
      do @(posedge clk); while (!(wr_if.valid && wr_if.ready));
    end
  end

  // Offer one pixel word, hold it until taken, then predict its write.
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic first);
    int gap;
    gap = src_burst ? 0 : $urandom_range(7);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid       <= 1'b1;
    pix_if.pixel       <= px;
    pix_if.first_pixel <= first;
    do @(posedge clk); while (!pix_if.ready);
    tracker.take_pixel(px, first);
    pixels_sent++;
  endtask

  // Leaves valid high so back-to-back writes need no second assignment per edge.
  task automatic cfg_write(input cfg_reg_e idx, input int value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_if.ready);
    tracker.set_reg(idx, value[CFG_DATA_W-1:0]);
  endtask

  task automatic apply_setting(input int bw, input int bh, input int sw, input int sh,
                               input int cx, input int cy);
    cfg_write(REG_BAND_WIDTH, bw);
    cfg_write(REG_BAND_HEIGHT, bh);
    cfg_write(REG_SPRITE_WIDTH, sw);
    cfg_write(REG_SPRITE_HEIGHT, sh);
    cfg_write(REG_CENTER_X, cx);
    cfg_write(REG_CENTER_Y, cy);
    cfg_if.valid <= 1'b0;
    settings++;
  endtask

  // Drop valid, drain every owed write, then let the pipeline empty.
  task automatic settle();
    pix_if.valid <= 1'b0;
    while (tracker.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Band sizes: empty, single pixel, exact max, saturating, and ordinary.
  function automatic int pick_band();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 1;
      2:       return int'(MAX_BAND_DIM);
      3:       return 1023;
      4:       return $urandom_range(513, 1023);
      5, 6:    return $urandom_range(2, 16);
      default: return $urandom_range(17, 511);
    endcase
  endfunction

  // Sprite sizes: mostly tiny so whole sprites stay cheap.
  function automatic int pick_sprite();
    case ($urandom_range(15))
      0:       return 0;
      1:       return int'(MAX_SPRITE_DIM);
      2:       return 255;
      3:       return $urandom_range(129, 254);
      4:       return $urandom_range(9, 127);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // Mostly place the sprite across the band so writes happen; sometimes far off.
  function automatic int pick_center(input int band_eff, input int spr);
    case ($urandom_range(7))
      0:       return -1024;
      1:       return 1023;
      2:       return int'($urandom_range(2047)) - 1024;
      default: return int'($urandom_range(0, band_eff + spr)) - spr / 2;
    endcase
  endfunction

  // Sprite content: a fair share of key hits and near misses of the key.
  function automatic logic [PIX_W-1:0] sprite_pixel(input logic [PIX_W-1:0] key);
    case ($urandom_range(7))
      0, 1:    return key;
      2:       return key ^ (16'h1 << $urandom_range(15));
      default: return PIX_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  initial begin
    int               bw, bh, sw, sh, cx, cy;
    int               total, len, mode, k, rand_sent;
    logic [PIX_W-1:0] key, px;
    logic             fp;

    pix_if.valid       <= 1'b0;
    pix_if.pixel       <= '0;
    pix_if.first_pixel <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= REG_BAND_WIDTH;
    cfg_if.data        <= '0;
    src_burst = 1'b0;
    snk_burst = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset sizes (320x240 band, 64x64 sprite); move the centre so the corner
    // lands at band (0,0). No marker yet: the key is still zero.
    cfg_write(REG_CENTER_X, 32);
    cfg_write(REG_CENTER_Y, 32);
    cfg_if.valid <= 1'b0;
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'h1234, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h00FF, 1'b0);
    settle();

    // 2x2 sprite in the far corner of a full band: top address. Key pixel,
    // a repeat of the key, then a second pass without a marker (counter wrap).
    apply_setting(512, 512, 2, 2, 511, 511);
    send_pixel(16'hA5A5, 1'b1);
    send_pixel(16'h5A5A, 1'b0);
    send_pixel(16'hA5A5, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'h8000, 1'b0);
    send_pixel(16'hA5A5, 1'b0);
    send_pixel(16'h7FFF, 1'b0);
    settle();

    // Zero-width band writes nothing; zero and oversize sprite dims clamp.
    apply_setting(0, 1023, 0, 255, -1024, -1024);
    send_pixel(16'h0F0F, 1'b1);
    send_pixel(16'hF0F0, 1'b0);
    send_pixel(16'h3C3C, 1'b0);
    settle();

    // Oversize band width saturates; 1x1 sprite revisits one spot every word.
    apply_setting(1023, 1, 0, 0, 511, 0);
    send_pixel(16'hBEEF, 1'b1);
    send_pixel(16'h1234, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hBEEF, 1'b0);
    settle();
    key = 16'hBEEF;

    // Random phases: new setting, then a few sprites, mostly whole and marked.
    rand_sent = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      bw = pick_band();
      bh = pick_band();
      sw = pick_sprite();
      sh = pick_sprite();
      if (tracker.sprite_dim(sw) > 16) sh = $urandom_range(3);
      else if (tracker.sprite_dim(sh) > 16) sw = $urandom_range(3);
      cx = pick_center(tracker.band_dim(bw), tracker.sprite_dim(sw));
      cy = pick_center(tracker.band_dim(bh), tracker.sprite_dim(sh));
      apply_setting(bw, bh, sw, sh, cx, cy);
      src_burst = ($urandom_range(3) == 0);
      snk_burst = ($urandom_range(3) == 0);
      total = tracker.sprite_dim(sw) * tracker.sprite_dim(sh);

      repeat ($urandom_range(1, 4)) begin
        mode = $urandom_range(9);
        case (mode)
          7:       len = $urandom_range(1, total);      // cut short
          8:       len = $urandom_range(1, 2 * total);  // unmarked, wraps
          9:       len = $urandom_range(1, 16);         // noise
          default: len = total;                         // whole sprite
        endcase
        // stop at the item budget
        if (len > RANDOM_ITEMS - rand_sent) len = RANDOM_ITEMS - rand_sent;
        for (k = 0; k < len; k++) begin
          if (k == 0 && mode <= 7) begin
            key = ($urandom_range(7) == 0) ? 16'h0000 : PIX_W'($urandom_range(16'hFFFF));
            send_pixel(key, 1'b1);
          end else if (mode == 9) begin
            fp = ($urandom_range(7) == 0);
            px = PIX_W'($urandom_range(16'hFFFF));
            send_pixel(px, fp);
            if (fp) key = px;
          end else begin
            send_pixel(sprite_pixel(key), 1'b0);
          end
        end
        rand_sent += len;
      end
      settle();
    end

    $display("Sent %0d pixel words over %0d register settings; %0d band writes checked.",
             pixels_sent, settings, tracker.matched);
    if (tracker.errors == 0 && tracker.due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
